@@ rtl/iq_power_peak_gain_zone_agc_unit_assert.svh @@
// ----------------------------------------------------------------------------
// IQ power AGC assertion macros
// Concurrent checks for simulation; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef IQ_POWER_PEAK_GAIN_ZONE_AGC_UNIT_ASSERT_SVH
`define IQ_POWER_PEAK_GAIN_ZONE_AGC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IPZAGC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipzagc: same-cycle check failed");
`define IPZAGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipzagc: next-cycle check failed");
`else
`define IPZAGC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define IPZAGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ipzagc_pkg.sv @@
// ----------------------------------------------------------------------------
// IQ power AGC package
// Widths, register codes, result word and zone gain tables.
// ----------------------------------------------------------------------------
package ipzagc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 17;
    localparam int LEVEL_W    = 32;
    localparam int ZONE_W     = 3;
    localparam int GAIN_W     = 7;
    localparam int SHIFT_W    = 8;
    localparam int DELAY_W    = 3;
    localparam int STATUS_W   = 3;

    // window length must be a power of two: the mean is a right shift
    localparam int WINDOW  = 16;
    localparam int WIN_LOG = $clog2(WINDOW);
    localparam int POWER_W = 2 * SAMPLE_W;
    localparam int SUM_W   = POWER_W + WIN_LOG;

    localparam int ZONE_COUNT      = 6;
    localparam int HIGH_ZONE_FIRST = 4;
    localparam int GAIN_MAX        = 72;

    localparam int MIN_LEN = 16;
    localparam int MAX_LEN = 65536;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0]   FRAME_LEN_RST  = LEN_W'(50000);
    localparam logic [LEN_W-1:0]   SEARCH_LEN_RST = LEN_W'(1024);
    localparam logic [LEVEL_W-1:0] MIN_LOW_RST    = LEVEL_W'(10000);
    localparam logic [LEVEL_W-1:0] MIN_HIGH_RST   = LEVEL_W'(40000);
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = LEVEL_W'(4000000);
    localparam logic [DELAY_W-1:0] DELAY_LIM_RST  = DELAY_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LEN,
        CFG_SEARCH_LEN,
        CFG_MIN_LOW,
        CFG_MIN_HIGH,
        CFG_MAX_LEVEL,
        CFG_DELAY_LIMIT
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_TRACK,
        ST_SEARCH,
        ST_SETTLED,
        ST_WEAK_TOP,
        ST_STRONG_BOTTOM
    } agc_status_t;

    typedef enum logic {
        MODE_TRACK,
        MODE_SEARCH
    } agc_mode_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] frame_peak;
        logic [LEVEL_W-1:0] reported_level;
        logic [ZONE_W-1:0]  zone;
        logic [DELAY_W-1:0] delay_count;
        agc_status_t        status;
    } frame_result_t;

    localparam logic signed [SHIFT_W-1:0] ZONE_SHIFT [2**ZONE_W] = '{
        -8'sd16, 8'sd0, 8'sd24, 8'sd48, 8'sd72, 8'sd88, 8'sd88, 8'sd88
    };

    function automatic logic [GAIN_W-1:0] zone_gain(input logic [ZONE_W-1:0] z);
        logic signed [SHIFT_W-1:0] s;
        logic [GAIN_W-1:0]         g;
        s = ZONE_SHIFT[z];
        if (z == '0) begin
            g = '0;
        end else if (z == ZONE_W'(ZONE_COUNT - 1)) begin
            g = GAIN_W'(GAIN_MAX);
        end else if (s > 8'sd72) begin
            g = GAIN_W'(GAIN_MAX);
        end else begin
            g = s[GAIN_W-1:0];
        end
        return g;
    endfunction

endpackage

@@ rtl/ipzagc_front.sv @@
// ----------------------------------------------------------------------------
// IQ power AGC front end
// Takes samples, forms window means and frame peaks, and runs the
// tracking/search decision, pushing one result word per frame.
// ----------------------------------------------------------------------------
module ipzagc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ipzagc_pkg::SAMPLE_W-1:0] s_sample_i,
    input  logic signed [ipzagc_pkg::SAMPLE_W-1:0] s_sample_q,
    input  logic                                cfg_wr_en,
    input  logic [ipzagc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ipzagc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [ipzagc_pkg::QCNT_W-1:0]       q_count,
    output logic                                q_push,
    output ipzagc_pkg::frame_result_t           q_entry
);
    import ipzagc_pkg::*;

    // configuration
    logic [LEN_W-1:0]   frame_len_reg, search_len_reg;
    logic [LEVEL_W-1:0] min_low_reg, min_high_reg, max_level_reg;
    logic [DELAY_W-1:0] delay_limit_reg;

    // sample counting
    logic [LEN_W-1:0]   sample_count_reg, sample_count_next;
    logic [LEN_W-1:0]   raw_len, len, count_inc;
    logic               accept, frame_end, win_end;

    // stage 1: squares
    logic               s1_valid_reg, s1_win_reg, s1_frm_reg;
    logic [POWER_W-1:0] s1_sq_i_reg, s1_sq_q_reg;
    logic signed [POWER_W-1:0] prod_i, prod_q;

    // stage 2: window sum
    logic               s2_valid_reg, s2_win_reg, s2_frm_reg;
    logic [SUM_W-1:0]   window_sum_reg, acc;
    logic [POWER_W-1:0] power;
    logic [LEVEL_W-1:0] mean_reg;

    // stage 3: frame peak
    logic               s3_valid_reg;
    logic [LEVEL_W-1:0] peak_reg, peak_cand, m_reg;

    // stage 4: decision state
    agc_mode_t          mode_reg, mode_next;
    logic [ZONE_W-1:0]  zone_reg, zone_next, zone_step;
    logic [DELAY_W-1:0] oor_reg, oor_next, oor_inc;
    logic [LEVEL_W-1:0] prev_reg, prev_next;
    logic [LEVEL_W-1:0] zmin_cur, zmin_step;
    agc_status_t        status;
    logic               stop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg   <= FRAME_LEN_RST;
            search_len_reg  <= SEARCH_LEN_RST;
            min_low_reg     <= MIN_LOW_RST;
            min_high_reg    <= MIN_HIGH_RST;
            max_level_reg   <= MAX_LEVEL_RST;
            delay_limit_reg <= DELAY_LIM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_LEN:   frame_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_SEARCH_LEN:  search_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_MIN_LOW:     min_low_reg     <= cfg_data[LEVEL_W-1:0];
                CFG_MIN_HIGH:    min_high_reg    <= cfg_data[LEVEL_W-1:0];
                CFG_MAX_LEVEL:   max_level_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_DELAY_LIMIT: delay_limit_reg <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // keep room for the one frame word that may be in flight
    assign s_ready = (q_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign accept  = s_valid && s_ready;

    always_comb begin
        raw_len = (mode_reg == MODE_SEARCH) ? search_len_reg : frame_len_reg;
        if (raw_len < LEN_W'(MIN_LEN)) begin
            len = LEN_W'(MIN_LEN);
        end else if (raw_len > LEN_W'(MAX_LEN)) begin
            len = LEN_W'(MAX_LEN);
        end else begin
            len = raw_len;
        end
    end

    assign count_inc         = sample_count_reg + LEN_W'(1);
    assign frame_end         = (count_inc >= len);
    assign win_end           = (sample_count_reg[WIN_LOG-1:0] == '1);
    assign sample_count_next = frame_end ? '0 : count_inc;

    assign prod_i = s_sample_i * s_sample_i;
    assign prod_q = s_sample_q * s_sample_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            s1_valid_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                sample_count_reg <= sample_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sq_i_reg <= $unsigned(prod_i);
            s1_sq_q_reg <= $unsigned(prod_q);
            s1_win_reg  <= win_end;
            s1_frm_reg  <= frame_end;
        end
    end

    assign power = s1_sq_i_reg + s1_sq_q_reg;
    assign acc   = window_sum_reg + SUM_W'(power);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_sum_reg <= '0;
            s2_valid_reg   <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                // drop the partial window at frame end
                window_sum_reg <= (s1_win_reg || s1_frm_reg) ? '0 : acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            mean_reg   <= acc[SUM_W-1:WIN_LOG];
            s2_win_reg <= s1_win_reg;
            s2_frm_reg <= s1_frm_reg;
        end
    end

    assign peak_cand = (s2_win_reg && (mean_reg > peak_reg)) ? mean_reg : peak_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg     <= '0;
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg && s2_frm_reg;
            if (s2_valid_reg) begin
                peak_reg <= s2_frm_reg ? '0 : peak_cand;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s2_frm_reg) begin
            m_reg <= peak_cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TRACK;
            zone_reg <= '0;
            oor_reg  <= '0;
            prev_reg <= '0;
        end else if (s3_valid_reg) begin
            mode_reg <= mode_next;
            zone_reg <= zone_next;
            oor_reg  <= oor_next;
            prev_reg <= prev_next;
        end
    end

    assign zmin_cur  = (zone_reg < ZONE_W'(HIGH_ZONE_FIRST)) ? min_low_reg : min_high_reg;
    assign oor_inc   = oor_reg + DELAY_W'(1);

    always_comb begin
        mode_next = mode_reg;
        zone_next = zone_reg;
        oor_next  = oor_reg;
        prev_next = prev_reg;
        status    = ST_TRACK;
        stop      = 1'b0;
        zone_step = zone_reg;
        zmin_step = zmin_cur;
        case (mode_reg)
            MODE_TRACK: begin
                if ((m_reg > zmin_cur) && (m_reg < max_level_reg)) begin
                    oor_next  = '0;
                    prev_next = m_reg;
                end else if (oor_inc >= delay_limit_reg) begin
                    oor_next  = '0;
                    mode_next = MODE_SEARCH;
                    status    = ST_SEARCH;
                end else begin
                    oor_next = oor_inc;
                end
            end
            MODE_SEARCH: begin
                oor_next = '0;
                status   = ST_SEARCH;
                if ((m_reg >= zmin_cur) && (m_reg <= max_level_reg)) begin
                    mode_next = MODE_TRACK;
                    status    = ST_SETTLED;
                end else begin
                    // step up when too weak, then down when too strong
                    if (m_reg < zmin_cur) begin
                        if (zone_reg < ZONE_W'(ZONE_COUNT - 1)) begin
                            zone_step = zone_reg + ZONE_W'(1);
                        end else begin
                            stop   = 1'b1;
                            status = ST_WEAK_TOP;
                        end
                    end
                    if (!stop && (m_reg > max_level_reg)) begin
                        if (zone_step != '0) begin
                            zone_step = zone_step - ZONE_W'(1);
                        end else begin
                            stop   = 1'b1;
                            status = ST_STRONG_BOTTOM;
                        end
                    end
                    zmin_step = (zone_step < ZONE_W'(HIGH_ZONE_FIRST)) ? min_low_reg
                                                                       : min_high_reg;
                    if (!stop && (m_reg >= zmin_step) && (m_reg <= max_level_reg)) begin
                        stop   = 1'b1;
                        status = ST_SETTLED;
                    end
                    if (stop) begin
                        mode_next = MODE_TRACK;
                    end
                    zone_next = zone_step;
                end
            end
            default: begin
                mode_next = MODE_TRACK;
            end
        endcase
    end

    assign q_push                 = s3_valid_reg;
    assign q_entry.frame_peak     = m_reg;
    assign q_entry.reported_level = prev_next;
    assign q_entry.zone           = zone_next;
    assign q_entry.delay_count    = oor_next;
    assign q_entry.status         = status;

endmodule

@@ rtl/ipzagc_queue.sv @@
// ----------------------------------------------------------------------------
// IQ power AGC result queue
// Short FIFO of frame result words between the front and back ends.
// ----------------------------------------------------------------------------
module ipzagc_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  ipzagc_pkg::frame_result_t     push_entry,
    input  logic                          pop,
    output logic                          head_valid,
    output ipzagc_pkg::frame_result_t     head_entry,
    output logic [ipzagc_pkg::QCNT_W-1:0] count
);
    import ipzagc_pkg::*;

    frame_result_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

@@ rtl/ipzagc_back.sv @@
// ----------------------------------------------------------------------------
// IQ power AGC back end
// Maps the zone to gain and switch settings and holds the result register.
// ----------------------------------------------------------------------------
module ipzagc_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 head_valid,
    input  ipzagc_pkg::frame_result_t            head_entry,
    output logic                                 pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ipzagc_pkg::LEVEL_W-1:0]       m_frame_peak,
    output logic [ipzagc_pkg::LEVEL_W-1:0]       m_reported_level,
    output logic [ipzagc_pkg::ZONE_W-1:0]        m_zone_index,
    output logic [ipzagc_pkg::GAIN_W-1:0]        m_rx_gain_db,
    output logic                                 m_lna_on,
    output logic                                 m_att_on,
    output logic signed [ipzagc_pkg::SHIFT_W-1:0] m_zone_shift_db,
    output logic [ipzagc_pkg::DELAY_W-1:0]       m_delay_count,
    output logic [ipzagc_pkg::STATUS_W-1:0]      m_agc_status
);
    import ipzagc_pkg::*;

    logic                      valid_reg;
    logic [LEVEL_W-1:0]        peak_reg, level_reg;
    logic [ZONE_W-1:0]         zone_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic                      lna_reg, att_reg;
    logic signed [SHIFT_W-1:0] shift_reg;
    logic [DELAY_W-1:0]        delay_reg;
    agc_status_t               status_reg;
    logic                      load;

    // refill whenever the output register is empty or being taken
    assign load = head_valid && (!valid_reg || m_ready);
    assign pop  = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            peak_reg   <= head_entry.frame_peak;
            level_reg  <= head_entry.reported_level;
            zone_reg   <= head_entry.zone;
            gain_reg   <= zone_gain(head_entry.zone);
            lna_reg    <= (head_entry.zone == ZONE_W'(ZONE_COUNT - 1));
            att_reg    <= (head_entry.zone == '0);
            shift_reg  <= ZONE_SHIFT[head_entry.zone];
            delay_reg  <= head_entry.delay_count;
            status_reg <= head_entry.status;
        end
    end

    assign m_valid          = valid_reg;
    assign m_frame_peak     = peak_reg;
    assign m_reported_level = level_reg;
    assign m_zone_index     = zone_reg;
    assign m_rx_gain_db     = gain_reg;
    assign m_lna_on         = lna_reg;
    assign m_att_on         = att_reg;
    assign m_zone_shift_db  = shift_reg;
    assign m_delay_count    = delay_reg;
    assign m_agc_status     = status_reg;

endmodule

@@ rtl/iq_power_peak_gain_zone_agc_unit.sv @@
// ----------------------------------------------------------------------------
// IQ power peak stepped-zone AGC, one sample per cycle sustained while the result queue has room.
// A frame's result passes the square, window-sum and frame-peak stages, the result queue and the output register.
// Input stalls only when the 4-entry result queue backs up from the output.
// Synchronous active-low reset: tracking mode, zone 0, counters/levels zero.
// ----------------------------------------------------------------------------
`include "iq_power_peak_gain_zone_agc_unit_assert.svh"

module iq_power_peak_gain_zone_agc_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ipzagc_pkg::SAMPLE_W-1:0] s_sample_i,
    input  logic signed [ipzagc_pkg::SAMPLE_W-1:0] s_sample_q,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ipzagc_pkg::LEVEL_W-1:0]        m_frame_peak,
    output logic [ipzagc_pkg::LEVEL_W-1:0]        m_reported_level,
    output logic [ipzagc_pkg::ZONE_W-1:0]         m_zone_index,
    output logic [ipzagc_pkg::GAIN_W-1:0]         m_rx_gain_db,
    output logic                                  m_lna_on,
    output logic                                  m_att_on,
    output logic signed [ipzagc_pkg::SHIFT_W-1:0] m_zone_shift_db,
    output logic [ipzagc_pkg::DELAY_W-1:0]        m_delay_count,
    output logic [ipzagc_pkg::STATUS_W-1:0]       m_agc_status,
    input  logic                                  cfg_wr_en,
    input  logic [ipzagc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ipzagc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ipzagc_pkg::*;

    logic              q_push, q_pop, q_head_valid;
    frame_result_t     q_entry, q_head;
    logic [QCNT_W-1:0] q_count;

    ipzagc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_i (s_sample_i),
        .s_sample_q (s_sample_q),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_count    (q_count),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    ipzagc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .count      (q_count)
    );

    ipzagc_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (q_head_valid),
        .head_entry       (q_head),
        .pop              (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_peak     (m_frame_peak),
        .m_reported_level (m_reported_level),
        .m_zone_index     (m_zone_index),
        .m_rx_gain_db     (m_rx_gain_db),
        .m_lna_on         (m_lna_on),
        .m_att_on         (m_att_on),
        .m_zone_shift_db  (m_zone_shift_db),
        .m_delay_count    (m_delay_count),
        .m_agc_status     (m_agc_status)
    );

    `IPZAGC_ASSERT_IMPLY(a_queue_room, aclk, aresetn, q_push, q_count != QCNT_W'(QUEUE_DEPTH))
    `IPZAGC_ASSERT_NEXT(a_push_lands, aclk, aresetn, q_push, q_count != '0)
    `IPZAGC_ASSERT_IMPLY(a_search_no_delay, aclk, aresetn, m_valid && (m_agc_status == ST_SEARCH), m_delay_count == '0)
    `IPZAGC_ASSERT_IMPLY(a_ext_exclusive, aclk, aresetn, m_valid, !(m_lna_on && m_att_on))

endmodule

@@ tb/iq_power_agc_checker.sv @@
// ----------------------------------------------------------------------------
// IQ power AGC frame checker
// Watches the sample, result and register ports of the AGC unit, keeps its
// own copy of the power windows, frame peak and zone search, and compares
// every result word field by field with the oldest predicted frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iq_power_agc_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic signed [ipzagc_pkg::SAMPLE_W-1:0] s_sample_i,
    input  logic signed [ipzagc_pkg::SAMPLE_W-1:0] s_sample_q,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [ipzagc_pkg::LEVEL_W-1:0]         m_frame_peak,
    input  logic [ipzagc_pkg::LEVEL_W-1:0]         m_reported_level,
    input  logic [ipzagc_pkg::ZONE_W-1:0]          m_zone_index,
    input  logic [ipzagc_pkg::GAIN_W-1:0]          m_rx_gain_db,
    input  logic                                   m_lna_on,
    input  logic                                   m_att_on,
    input  logic signed [ipzagc_pkg::SHIFT_W-1:0]  m_zone_shift_db,
    input  logic [ipzagc_pkg::DELAY_W-1:0]         m_delay_count,
    input  logic [ipzagc_pkg::STATUS_W-1:0]        m_agc_status,
    input  logic                                   cfg_wr_en,
    input  logic [ipzagc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ipzagc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                     err_count,
    output int                                     pending_count,
    output int                                     frames_predicted,
    output int                                     frames_checked
);
    import ipzagc_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0]        peak;
        logic [LEVEL_W-1:0]        level;
        logic [ZONE_W-1:0]         zone;
        logic [GAIN_W-1:0]         gain;
        logic                      lna;
        logic                      att;
        logic signed [SHIFT_W-1:0] shift;
        logic [DELAY_W-1:0]        delay;
        agc_status_t               status;
    } agc_frame_t;

    // register copy
    logic [LEN_W-1:0]   frame_len_r;
    logic [LEN_W-1:0]   search_len_r;
    logic [LEVEL_W-1:0] min_low_r;
    logic [LEVEL_W-1:0] min_high_r;
    logic [LEVEL_W-1:0] max_lvl_r;
    logic [DELAY_W-1:0] delay_lim_r;

    // frame and zone state
    logic [LEN_W-1:0]   smp_cnt;
    logic [SUM_W-1:0]   win_acc;
    logic [LEVEL_W-1:0] peak_lvl;
    logic [LEVEL_W-1:0] prev_level;
    logic [ZONE_W-1:0]  zone_r;
    logic [DELAY_W-1:0] oor_cnt;
    agc_mode_t          mode;

    agc_frame_t expected_frames[$];

    function automatic logic [LEN_W:0] effective_len(input logic [LEN_W-1:0] v);
        if (v < LEN_W'(MIN_LEN)) return (LEN_W + 1)'(MIN_LEN);
        if (v > LEN_W'(MAX_LEN)) return (LEN_W + 1)'(MAX_LEN);
        return {1'b0, v};
    endfunction

    function automatic logic [LEVEL_W-1:0] zone_floor(input logic [ZONE_W-1:0] z);
        return (z < ZONE_W'(HIGH_ZONE_FIRST)) ? min_low_r : min_high_r;
    endfunction

    function automatic logic in_bounds(input logic [LEVEL_W-1:0] lvl,
                                       input logic [ZONE_W-1:0] z);
        return !(lvl < zone_floor(z) || lvl > max_lvl_r);
    endfunction

    function automatic logic signed [SHIFT_W-1:0] zone_shift(input logic [ZONE_W-1:0] z);
        case (z)
            3'd0:    return -8'sd16;
            3'd1:    return 8'sd0;
            3'd2:    return 8'sd24;
            3'd3:    return 8'sd48;
            3'd4:    return 8'sd72;
            default: return 8'sd88;
        endcase
    endfunction

    // one search frame: step up when weak, then down when strong
    function automatic agc_status_t zone_search_step(input logic [LEVEL_W-1:0] lvl);
        if (in_bounds(lvl, zone_r)) begin
            mode = MODE_TRACK;
            return ST_SETTLED;
        end
        if (lvl < zone_floor(zone_r)) begin
            if (zone_r < ZONE_W'(ZONE_COUNT - 1)) begin
                zone_r = zone_r + 1'b1;
            end else begin
                mode = MODE_TRACK;
                return ST_WEAK_TOP;
            end
        end
        if (lvl > max_lvl_r) begin
            if (zone_r > '0) begin
                zone_r = zone_r - 1'b1;
            end else begin
                mode = MODE_TRACK;
                return ST_STRONG_BOTTOM;
            end
        end
        if (in_bounds(lvl, zone_r)) begin
            mode = MODE_TRACK;
            return ST_SETTLED;
        end
        return ST_SEARCH;
    endfunction

    task automatic advance_sample(input logic signed [SAMPLE_W-1:0] si,
                                  input logic signed [SAMPLE_W-1:0] sq);
        longint             pwr;
        logic [LEVEL_W-1:0] mean;
        logic [LEVEL_W-1:0] lvl;
        logic [LEN_W:0]     next_pos;
        logic [LEN_W:0]     len;
        agc_frame_t         f;
        pwr = longint'(si) * longint'(si) + longint'(sq) * longint'(sq);
        win_acc = win_acc + SUM_W'(pwr);
        next_pos = {1'b0, smp_cnt} + 1'b1;
        if (smp_cnt[WIN_LOG-1:0] == '1) begin
            mean = LEVEL_W'(win_acc >> WIN_LOG);
            if (mean > peak_lvl) peak_lvl = mean;
            win_acc = '0;
        end
        len = effective_len((mode == MODE_SEARCH) ? search_len_r : frame_len_r);
        if (next_pos < len) begin
            smp_cnt = next_pos[LEN_W-1:0];
        end else begin
            // frame end: drop any partial window
            lvl = peak_lvl;
            smp_cnt = '0;
            win_acc = '0;
            peak_lvl = '0;
            if (mode == MODE_TRACK) begin
                f.status = ST_TRACK;
                if (lvl > zone_floor(zone_r) && lvl < max_lvl_r) begin
                    oor_cnt = '0;
                    prev_level = lvl;
                end else begin
                    oor_cnt = oor_cnt + 1'b1;
                    if (oor_cnt >= delay_lim_r) begin
                        oor_cnt = '0;
                        mode = MODE_SEARCH;
                        f.status = ST_SEARCH;
                    end
                end
            end else begin
                oor_cnt = '0;
                f.status = zone_search_step(lvl);
            end
            f.peak  = lvl;
            f.level = prev_level;
            f.zone  = zone_r;
            f.shift = zone_shift(zone_r);
            if (zone_r == '0) begin
                f.gain = '0;
            end else if (zone_r == ZONE_W'(ZONE_COUNT - 1)) begin
                f.gain = GAIN_W'(GAIN_MAX);
            end else if (f.shift > 8'sd72) begin
                f.gain = GAIN_W'(GAIN_MAX);
            end else begin
                f.gain = f.shift[GAIN_W-1:0];
            end
            f.lna   = (zone_r == ZONE_W'(ZONE_COUNT - 1));
            f.att   = (zone_r == '0);
            f.delay = oor_cnt;
            expected_frames.push_back(f);
            frames_predicted++;
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            err_count++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        agc_frame_t want;
        if (!aresetn) begin
            frame_len_r  = FRAME_LEN_RST;
            search_len_r = SEARCH_LEN_RST;
            min_low_r    = MIN_LOW_RST;
            min_high_r   = MIN_HIGH_RST;
            max_lvl_r    = MAX_LEVEL_RST;
            delay_lim_r  = DELAY_LIM_RST;
            smp_cnt      = '0;
            win_acc      = '0;
            peak_lvl     = '0;
            prev_level   = '0;
            zone_r       = '0;
            oor_cnt      = '0;
            mode         = MODE_TRACK;
            expected_frames.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FRAME_LEN:   frame_len_r  = cfg_data[LEN_W-1:0];
                    CFG_SEARCH_LEN:  search_len_r = cfg_data[LEN_W-1:0];
                    CFG_MIN_LOW:     min_low_r    = cfg_data[LEVEL_W-1:0];
                    CFG_MIN_HIGH:    min_high_r   = cfg_data[LEVEL_W-1:0];
                    CFG_MAX_LEVEL:   max_lvl_r    = cfg_data[LEVEL_W-1:0];
                    CFG_DELAY_LIMIT: delay_lim_r  = cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting: a word cannot stem from this edge's sample
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    err_count++;
                    $error("result word with no frame pending: frame_peak %0d", m_frame_peak);
                end else begin
                    want = expected_frames.pop_front();
                    check_field("frame_peak", want.peak, m_frame_peak);
                    check_field("reported_level", want.level, m_reported_level);
                    check_field("zone_index", want.zone, m_zone_index);
                    check_field("rx_gain_db", want.gain, m_rx_gain_db);
                    check_field("lna_on", want.lna, m_lna_on);
                    check_field("att_on", want.att, m_att_on);
                    check_field("zone_shift_db", want.shift, m_zone_shift_db);
                    check_field("delay_count", want.delay, m_delay_count);
                    check_field("agc_status", want.status, m_agc_status);
                    frames_checked++;
                end
            end
            if (s_valid && s_ready) advance_sample(s_sample_i, s_sample_q);
        end
        pending_count = expected_frames.size();
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// IQ power AGC testbench
// Drives I/Q samples and register settings into the AGC unit with random
// gaps and output stalls, including a long output hold-off and long
// frames; a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ipzagc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_SAMPLES  = 500;
    localparam int RANDOM_FRAMES   = 12;

    localparam logic signed [SAMPLE_W-1:0] EDGE_I [16] = '{
        16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000,
        16'shFFFF, 16'sh0001, 16'sh0000, 16'sh8000
    };
    localparam logic signed [SAMPLE_W-1:0] EDGE_Q [16] = '{
        16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000,
        16'shFFFF, 16'sh0001, 16'sh7FFF, 16'sh0000
    };
    localparam int AMP_BITS [6] = '{0, 4, 7, 10, 13, 16};

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [SAMPLE_W-1:0]  s_sample_i;
    logic signed [SAMPLE_W-1:0]  s_sample_q;
    logic                        m_valid;
    logic                        m_ready;
    logic [LEVEL_W-1:0]          m_frame_peak;
    logic [LEVEL_W-1:0]          m_reported_level;
    logic [ZONE_W-1:0]           m_zone_index;
    logic [GAIN_W-1:0]           m_rx_gain_db;
    logic                        m_lna_on;
    logic                        m_att_on;
    logic signed [SHIFT_W-1:0]   m_zone_shift_db;
    logic [DELAY_W-1:0]          m_delay_count;
    logic [STATUS_W-1:0]         m_agc_status;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    int err_count;
    int pending;
    int frames_predicted;
    int frames_checked;

    int samples_sent;
    int settings_used;
    int chunk_left;
    int amp_bits;
    bit no_gaps;
    bit hold_off_req;

    iq_power_peak_gain_zone_agc_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_i       (s_sample_i),
        .s_sample_q       (s_sample_q),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_peak     (m_frame_peak),
        .m_reported_level (m_reported_level),
        .m_zone_index     (m_zone_index),
        .m_rx_gain_db     (m_rx_gain_db),
        .m_lna_on         (m_lna_on),
        .m_att_on         (m_att_on),
        .m_zone_shift_db  (m_zone_shift_db),
        .m_delay_count    (m_delay_count),
        .m_agc_status     (m_agc_status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    iq_power_agc_checker frame_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_i       (s_sample_i),
        .s_sample_q       (s_sample_q),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_peak     (m_frame_peak),
        .m_reported_level (m_reported_level),
        .m_zone_index     (m_zone_index),
        .m_rx_gain_db     (m_rx_gain_db),
        .m_lna_on         (m_lna_on),
        .m_att_on         (m_att_on),
        .m_zone_shift_db  (m_zone_shift_db),
        .m_delay_count    (m_delay_count),
        .m_agc_status     (m_agc_status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .err_count        (err_count),
        .pending_count    (pending),
        .frames_predicted (frames_predicted),
        .frames_checked   (frames_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // amplitude held over chunks so frame peaks land in different zones
    task automatic random_word(output logic signed [SAMPLE_W-1:0] si,
                               output logic signed [SAMPLE_W-1:0] sq);
        logic signed [SAMPLE_W-1:0] raw_i;
        logic signed [SAMPLE_W-1:0] raw_q;
        if (chunk_left == 0) begin
            chunk_left = $urandom_range(16, 64);
            amp_bits = AMP_BITS[$urandom_range(0, 5)];
        end
        chunk_left--;
        raw_i = SAMPLE_W'($urandom);
        raw_q = SAMPLE_W'($urandom);
        si = raw_i >>> (SAMPLE_W - amp_bits);
        sq = raw_q >>> (SAMPLE_W - amp_bits);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                               input logic signed [SAMPLE_W-1:0] sq);
        int gap;
        gap = no_gaps ? 0 : idle_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_sample_i <= si;
        s_sample_q <= sq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic send_random(input int count);
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
        repeat (count) begin
            random_word(si, sq);
            send_sample(si, sq);
        end
    endtask

    // drop valid, wait for every pending frame, then let the pipeline drain
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic program_regs(input logic [LEN_W-1:0] fl, input logic [LEN_W-1:0] sl,
                                input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi,
                                input logic [LEVEL_W-1:0] mx, input logic [DELAY_W-1:0] dl);
        write_reg(CFG_FRAME_LEN, CFG_DATA_W'(fl));
        write_reg(CFG_SEARCH_LEN, CFG_DATA_W'(sl));
        write_reg(CFG_MIN_LOW, lo);
        write_reg(CFG_MIN_HIGH, hi);
        write_reg(CFG_MAX_LEVEL, mx);
        write_reg(CFG_DELAY_LIMIT, CFG_DATA_W'(dl));
        // unused indexes must leave every register alone
        if ($urandom_range(0, 3) == 0) begin
            write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        int free_left;
        bit hold_off_done;
        stall_left    = 0;
        hold_left     = 0;
        free_left     = 0;
        hold_off_done = 1'b0;
        m_ready       = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (free_left > 0) begin
                free_left--;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 39) == 0) free_left = $urandom_range(40, 200);
                else stall_left = idle_gap();
            end
        end
    end

    initial begin : stimulus
        logic [LEN_W-1:0]   fl;
        logic [LEN_W-1:0]   sl;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
        logic [LEVEL_W-1:0] mx;
        int                 rand_start;
        int                 frames_start;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_sample_i   = '0;
        s_sample_q   = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_FRAME_LEN;
        cfg_data     = '0;
        samples_sent = 0;
        settings_used = 0;
        chunk_left   = 0;
        amp_bits     = 0;
        no_gaps      = 1'b0;
        hold_off_req = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // full-scale window; zero delay limit sends the first bad frame to search
        write_reg(CFG_SPARE_HI, '1);
        program_regs(17'd0, 17'd16, 32'd10000, 32'd40000, 32'd4000000, 3'd0);
        foreach (EDGE_I[k]) send_sample(EDGE_I[k], EDGE_Q[k]);
        quiesce();

        // shorten the search frame after it has run past the new length
        program_regs(17'd16, 17'd24, 32'd10000, 32'd40000, 32'd4000000, 3'd0);
        repeat (19) send_sample(16'sh8000, 16'sh8000);
        quiesce();
        program_regs(17'd16, 17'd16, 32'd10000, 32'd40000, 32'd4000000, 3'd0);
        send_sample(16'sh7FFF, 16'sh8000);
        quiesce();

        // long search frame: an empty tracking frame starts the search
        program_regs(17'd16, 17'd256, 32'd0, 32'd0, 32'hFFFF_FFFF, 3'd1);
        no_gaps = 1'b1;
        repeat (16) send_sample(16'sh0000, 16'sh0000);
        send_random(256);
        quiesce();

        // long tracking frame with the largest delay limit
        program_regs(17'd160, 17'd16, 32'd10000, 32'd40000, 32'd4000000, 3'd7);
        send_random(160);
        quiesce();

        // hold the output off while words keep coming, so the input backs up
        program_regs(17'd16, 17'd16, 32'd10000, 32'd40000, 32'd4000000, 3'd3);
        hold_off_req = 1'b1;
        send_random(256);
        no_gaps = 1'b0;
        quiesce();

        rand_start   = samples_sent;
        frames_start = frames_predicted;
        while (samples_sent - rand_start < RANDOM_SAMPLES ||
               frames_predicted - frames_start < RANDOM_FRAMES) begin
            fl = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, 15))
                                             : LEN_W'($urandom_range(16, 48));
            sl = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, 15))
                                             : LEN_W'($urandom_range(16, 40));
            case ($urandom_range(0, 4))
                0: begin
                    lo = 32'd10000;
                    hi = 32'd40000;
                    mx = 32'd4000000;
                end
                1: begin
                    lo = $urandom_range(1000, 60000);
                    hi = lo + $urandom_range(0, 200000);
                    mx = $urandom_range(1000000, 100000000);
                end
                2: begin
                    // minimum above maximum
                    lo = $urandom_range(1000000, 5000000);
                    hi = lo;
                    mx = $urandom_range(0, 500000);
                end
                3: begin
                    lo = 32'd0;
                    hi = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'hFFFF_FFFF;
                    mx = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
                end
                default: begin
                    lo = $urandom;
                    hi = $urandom;
                    mx = $urandom;
                end
            endcase
            program_regs(fl, sl, lo, hi, mx, DELAY_W'($urandom_range(0, 7)));
            no_gaps = ($urandom_range(0, 4) == 0);
            send_random($urandom_range(40, 160));
            quiesce();
        end

        $display("Summary: %0d samples, %0d frame words checked, %0d register settings",
                 samples_sent, frames_checked, settings_used);
        $display("Summary: frames from the 16-sample floor to 256, long output hold-off");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ iq_power_peak_gain_zone_agc_unit.f @@
+incdir+rtl
rtl/ipzagc_pkg.sv
rtl/ipzagc_front.sv
rtl/ipzagc_queue.sv
rtl/ipzagc_back.sv
rtl/iq_power_peak_gain_zone_agc_unit.sv
tb/iq_power_agc_checker.sv
tb/testbench.sv
